/* hdl/xkc_pkg.sv */
// Shared types, constants and the CRC-8 byte update for the XOR-key cipher.
package xkc_pkg;

  localparam int unsigned NumLanes = 4;
  localparam logic [7:0] CrcStart = 8'h7F;
  localparam logic [7:0] CrcPolyRefl = 8'h8C;
  localparam logic [2:0] FullCount = 3'd4;
  localparam logic [0:0] RegDecryptMode = 1'b0;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic [31:0] cipher_key;
    logic        first_word;
    logic        last_word;
  } xkc_in_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic [2:0]  out_byte_count;
    logic [7:0]  checksum;
    logic        last_out;
  } xkc_out_t;

  // What one byte lane hands to the merging stage.
  typedef struct packed {
    logic       en;
    logic [7:0] ct;
    logic [7:0] pt;
  } xkc_lane_t;

  // Reflected CRC-8 update of one byte, polynomial 0x8C.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPolyRefl) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* hdl/xkc_lane.sv */
// One byte lane: XOR of a data byte with its key byte and plaintext selection.
module xkc_lane (
  input  logic              en_i,
  input  logic              full_i,
  input  logic              decrypt_i,
  input  logic [7:0]        data_i,
  input  logic [7:0]        key_full_i,
  input  logic [7:0]        key_low_i,
  output xkc_pkg::xkc_lane_t lane_o
);
  import xkc_pkg::*;

  logic [7:0] key_byte;
  logic [7:0] xored;

  // A full word uses its own key byte; a short word uses the key's low byte.
  assign key_byte = full_i ? key_full_i : key_low_i;
  assign xored    = data_i ^ key_byte;

  assign lane_o.en = en_i;
  assign lane_o.ct = en_i ? xored : 8'h00;
  assign lane_o.pt = decrypt_i ? xored : data_i;
endmodule

/* hdl/xkc_merge.sv */
// Merging stage: assembles the output word and runs the CRC over lane plaintext.
module xkc_merge (
  input  xkc_pkg::xkc_lane_t [3:0] lanes_i,
  input  logic                     full_i,
  input  logic [2:0]               count_i,
  input  logic                     first_i,
  input  logic                     last_i,
  input  logic [7:0]               crc_q_i,
  output logic [7:0]               crc_d_o,
  output xkc_pkg::xkc_out_t        res_o
);
  import xkc_pkg::*;

  logic [7:0] crc_start;
  logic [7:0] crc1;
  logic [7:0] crc2;
  logic [7:0] crc3;
  logic [1:0] n_bytes;

  assign crc_start = first_i ? CrcStart : crc_q_i;
  // A full word feeds only its low byte; a short word feeds each valid byte.
  assign n_bytes   = full_i ? 2'd1 : count_i[1:0];

  assign crc1 = crc8_byte(crc_start, lanes_i[0].pt);
  assign crc2 = crc8_byte(crc1, lanes_i[1].pt);
  assign crc3 = crc8_byte(crc2, lanes_i[2].pt);

  always_comb begin
    case (n_bytes)
      2'd0:    crc_d_o = crc_start;
      2'd1:    crc_d_o = crc1;
      2'd2:    crc_d_o = crc2;
      2'd3:    crc_d_o = crc3;
      default: crc_d_o = crc_start;
    endcase
  end

  assign res_o.data_out       = {lanes_i[3].ct, lanes_i[2].ct, lanes_i[1].ct, lanes_i[0].ct};
  assign res_o.out_byte_count = count_i;
  assign res_o.checksum       = crc_d_o;
  assign res_o.last_out       = last_i;
endmodule

/* hdl/xor_key_cipher_with_crc8.sv */
// Top level of the XOR-key packet cipher with a running CRC-8 checksum.
//
// Input channel: one transaction carries one little-endian packet word with
// its byte count, the packet key and first/last marks. Output channel: one
// transaction per input word carrying the transformed word, the effective
// byte count, the running checksum after that word and the last mark.
// The decrypt_mode register sits at byte address 0 of the APB-style port;
// it selects whether the checksum covers input (encrypt) or output
// (decrypt) bytes. It should only be written while the block is idle.
// A word accepted on the input is offered on the output from the next cycle.
// Throughput is one word per cycle while results are taken; a combinational
// chain of up to three CRC byte updates feeds the checksum register.
// The output register frees itself when the receiver takes a transaction, so
// input and output move in the same cycle. When the receiver stalls, the
// result holds and the input is refused until it is taken.
// Reset clears the output valid, restarts the checksum at 0x7F and selects
// encrypt mode.
module xor_key_cipher_with_crc8 (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  xkc_pkg::xkc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output xkc_pkg::xkc_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import xkc_pkg::*;

  logic              decrypt_q;
  logic              decrypt_d;
  logic [7:0]        crc_q;
  logic [7:0]        crc_d;
  logic              out_valid_q;
  logic              out_valid_d;
  xkc_out_t          out_q;
  xkc_out_t          res;
  logic              in_fire;
  logic [2:0]        count_sat;
  logic              full;
  xkc_lane_t [3:0]   lanes;

  // Register index comes from the word address bit; register 0 is the mode.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegDecryptMode) ? {31'd0, decrypt_q} : 32'd0;
  assign decrypt_d = (psel && penable && pwrite && (paddr[2] == RegDecryptMode))
                     ? pwdata[0] : decrypt_q;

  // Counts above four are treated as a full word.
  assign count_sat = (in_data_i.byte_count > FullCount) ? FullCount : in_data_i.byte_count;
  assign full      = (count_sat == FullCount);

  // The output register accepts a new transaction when empty or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    xkc_lane u_lane (
      .en_i       (full || (3'(g) < count_sat)),
      .full_i     (full),
      .decrypt_i  (decrypt_q),
      .data_i     (in_data_i.data_word[8*g +: 8]),
      .key_full_i (in_data_i.cipher_key[8*g +: 8]),
      .key_low_i  (in_data_i.cipher_key[7:0]),
      .lane_o     (lanes[g])
    );
  end

  xkc_merge u_merge (
    .lanes_i (lanes),
    .full_i  (full),
    .count_i (count_sat),
    .first_i (in_data_i.first_word),
    .last_i  (in_data_i.last_word),
    .crc_q_i (crc_q),
    .crc_d_o (crc_d),
    .res_o   (res)
  );

  assign out_valid_d = in_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q   <= 1'b0;
      crc_q       <= CrcStart;
      out_valid_q <= 1'b0;
    end else begin
      decrypt_q   <= decrypt_d;
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        crc_q <= crc_d;
      end
    end
  end

  // The payload register needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule
